### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window maximum.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int WIN_CFG_W = 7;

    // Register word indexes (paddr[PADDR_W-1:2])
    localparam logic [PADDR_W-3:0] REG_WINDOW_SIZE = '0;

    // Fan-in of one reduction node
    localparam int RADIX_LOG = 3;
    localparam int RADIX     = 1 << RADIX_LOG;

    // Per-item control broadcast to every cell
    typedef struct packed {
        logic shift;    // item accepted, chain moves one place
        logic restart;  // item opens a new sequence
    } cell_ctrl_t;

endpackage

### hw/rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sample delay line with its candidate flag.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cell_ctrl_t                     ctrl,
    input  logic                           fresh,      // head slot: takes the new item
    input  logic                           in_window,  // slot age below window size
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] in_value,
    input  logic                           in_alive,
    output logic signed [SAMPLE_WIDTH-1:0] out_value,
    output logic                           out_alive
);

    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic                           alive_reg;
    logic                           alive_next;

    // A candidate survives in the window above the newest item, unless restarted.
    always_comb begin
        alive_next = fresh
                   | (in_alive & in_window & ~ctrl.restart & (in_value > sample));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= 1'b0;
        end else if (ctrl.shift) begin
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= in_value;
        end
    end

    assign out_value = value_reg;
    assign out_alive = alive_reg;

endmodule

### hw/rtl/swm_node.sv
// ----------------------------------------------------------------------------
// swm_node
// Registered reduction node: keeps the oldest live input of its group.
// ----------------------------------------------------------------------------
module swm_node import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic [RADIX-1:0]                   in_alive,
    input  logic [RADIX-1:0][SAMPLE_WIDTH-1:0] in_value,
    output logic                               out_alive,
    output logic [SAMPLE_WIDTH-1:0]            out_value
);

    logic                    alive_reg;
    logic                    alive_next;
    logic [SAMPLE_WIDTH-1:0] value_reg;
    logic [SAMPLE_WIDTH-1:0] value_next;

    // Higher input index is older; last live one wins.
    always_comb begin
        alive_next = 1'b0;
        value_next = in_value[0];
        for (int k = 0; k < RADIX; k++) begin
            if (in_alive[k]) begin
                alive_next = 1'b1;
                value_next = in_value[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= 1'b0;
        end else if (en) begin
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
        end
    end

    assign out_alive = alive_reg;
    assign out_value = value_reg;

endmodule

### hw/rtl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming maximum of the last window_size signed samples.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one item per handshake (s_sample, s_restart). s_restart marks
//    the first sample of a new sequence and drops everything seen before it.
//  - m_ channel: m_window_max, one result per item once window_size samples
//    have arrived since the last restart; earlier items give no result.
//  - APB register 0 (byte address 0): window_size, 7 bits, reset 1. Zero acts
//    as 1, values above WINDOW_MAX act as WINDOW_MAX. Write only while idle.
//  - Throughput: one item per clock unless stalled. The samples sit in a chain of
//    WINDOW_MAX cells, each shifting to its neighbor on every item and
//    keeping a live flag for a still possible maximum.
//  - Search: the oldest live cell is found by a registered tree of 8-input
//    nodes, ceil(log8(WINDOW_MAX)) levels (2 at the default size); the result
//    flag is registered level by level alongside the tree.
//  - Stall: while m_valid waits on m_ready the whole pipe holds and s_ready
//    is low; no item or result is lost.
//  - Reset (aresetn, synchronous): clears all live flags, the sample count
//    and the pipe; window_size returns to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_maximum import swm_pkg::*; #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_restart,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_window_max,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [PADDR_W-1:0]             paddr,
    input  logic [PDATA_W-1:0]             pwdata,
    output logic [PDATA_W-1:0]             prdata,
    output logic                           pready
);

    // Tree shape
    localparam int LOG8   = ($clog2(WINDOW_MAX) + RADIX_LOG - 1) / RADIX_LOG;
    localparam int LEVELS = (LOG8 < 1) ? 1 : LOG8;
    localparam int PAD    = 1 << (RADIX_LOG * LEVELS);

    // Window count width: holds WINDOW_MAX and any register value
    localparam int WW_MIN = $clog2(WINDOW_MAX + 1);
    localparam int WW     = (WW_MIN > WIN_CFG_W) ? WW_MIN : WIN_CFG_W;

    // First node index of a tree level; leaves are level 0.
    function automatic int level_offset(input int lvl);
        int off;
        off = 0;
        for (int k = 0; k < lvl; k++) begin
            off += 1 << (RADIX_LOG * (LEVELS - k));
        end
        return off;
    endfunction

    localparam int TOT  = level_offset(LEVELS + 1);
    localparam int ROOT = TOT - 1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [WIN_CFG_W-1:0] window_size_reg;
    logic [WIN_CFG_W-1:0] window_size_next;
    logic [PADDR_W-3:0]   reg_idx;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        window_size_next = window_size_reg;
        prdata           = '0;
        unique case (reg_idx)
            REG_WINDOW_SIZE: begin
                prdata = PDATA_W'(window_size_reg);
                if (cfg_write) begin
                    window_size_next = pwdata[WIN_CFG_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_CFG_W'(1);
        end else begin
            window_size_reg <= window_size_next;
        end
    end

    // Effective window: zero reads as one, clamp at the chain length.
    logic [WW-1:0] ws_ext;
    logic [WW-1:0] w_eff;

    assign ws_ext = WW'(window_size_reg);

    always_comb begin
        if (ws_ext == '0) begin
            w_eff = WW'(1);
        end else if (ws_ext > WW'(WINDOW_MAX)) begin
            w_eff = WW'(WINDOW_MAX);
        end else begin
            w_eff = ws_ext;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: everything moves when the output slot can advance.
    // ------------------------------------------------------------------
    logic en;
    logic s_accept;

    assign en       = ~m_valid | m_ready;
    assign s_ready  = en;
    assign s_accept = s_valid & s_ready;

    // Samples since restart, saturating at the window size
    logic [WW-1:0] seen_reg;
    logic [WW-1:0] seen_next;
    logic [WW-1:0] seen_base;
    logic          produce;

    always_comb begin
        seen_base = s_restart ? '0 : seen_reg;
        seen_next = (seen_base < w_eff) ? seen_base + WW'(1) : w_eff;
        produce   = (seen_next == w_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (s_accept) begin
            seen_reg <= seen_next;
        end
    end

    // Result flag rides along the tree levels
    logic [LEVELS:0] vld_reg;
    logic [LEVELS:0] vld_next;

    always_comb begin
        vld_next = {vld_reg[LEVELS-1:0], s_accept & produce};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    assign m_valid = vld_reg[LEVELS];

    // ------------------------------------------------------------------
    // Cell chain: cell i holds the sample of age i.
    // ------------------------------------------------------------------
    cell_ctrl_t                                   cell_ctrl;
    logic [WINDOW_MAX:0]                          chain_alive;
    logic signed [SAMPLE_WIDTH-1:0]               chain_value [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]                        in_win;
    logic [WINDOW_MAX-1:0]                        alive_vec;

    assign cell_ctrl.shift   = s_accept;
    assign cell_ctrl.restart = s_restart;
    assign chain_alive[0]    = 1'b1;
    assign chain_value[0]    = s_sample;
    assign alive_vec         = chain_alive[WINDOW_MAX:1];

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        assign in_win[i] = (WW'(i) < w_eff);

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .fresh     ((i == 0) ? 1'b1 : 1'b0),
            .in_window (in_win[i]),
            .sample    (s_sample),
            .in_value  (chain_value[i]),
            .in_alive  (chain_alive[i]),
            .out_value (chain_value[i+1]),
            .out_alive (chain_alive[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Reduction tree: live candidates rise in value with age, so the
    // oldest live cell is the window maximum.
    // ------------------------------------------------------------------
    logic [TOT-1:0]                   node_alive;
    logic [TOT-1:0][SAMPLE_WIDTH-1:0] node_value;

    for (genvar i = 0; i < PAD; i++) begin : g_leaf
        if (i < WINDOW_MAX) begin : g_used
            assign node_alive[i] = chain_alive[i+1];
            assign node_value[i] = chain_value[i+1];
        end else begin : g_pad
            assign node_alive[i] = 1'b0;
            assign node_value[i] = '0;
        end
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_level
        localparam int NODES = 1 << (RADIX_LOG * (LEVELS - l));
        localparam int SRC   = level_offset(l - 1);
        localparam int DST   = level_offset(l);

        for (genvar n = 0; n < NODES; n++) begin : g_node
            swm_node #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_node (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_alive  (node_alive[SRC + n*RADIX +: RADIX]),
                .in_value  (node_value[SRC + n*RADIX +: RADIX]),
                .out_alive (node_alive[DST + n]),
                .out_value (node_value[DST + n])
            );
        end
    end

    assign m_window_max = node_value[ROOT];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_head_live, aclk, aresetn, s_accept, chain_alive[1], "head cell not live after an item")
    `ASSERT_NEXT(a_restart_single, aclk, aresetn, s_accept && s_restart, $onehot(alive_vec), "restart left stale candidates")
    `ASSERT_PROP(a_result_has_candidate, aclk, aresetn, m_valid |-> node_alive[ROOT], "result without a live candidate")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for sliding_window_maximum. A short directed item
// table (extremes, window sizes zero and above the maximum, equal samples,
// mid-sequence window changes, the no-result fill phase) is followed by about
// 2000 random items in phases with different window sizes and idle patterns.
// Every accepted item runs through a monotonic-queue predictor and each result
// is checked against the oldest pending window maximum.
// ----------------------------------------------------------------------------
module testbench import swm_pkg::*; ();

    localparam int WINDOW_DEPTH = 64;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 12;       // well past the two-level tree latency
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int CYCLE_LIMIT  = 300000;
    localparam int ROW_SLOTS    = 64;       // directed table capacity
    localparam int PEND_DEPTH   = 16;       // owed results, well above the pipe depth

    localparam logic [PADDR_W-1:0] WIN_ADDR = {REG_WINDOW_SIZE, 2'b00};

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_sample  = '0;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [31:0] m_window_max;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sliding_window_maximum dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_window_max (m_window_max),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: monotonic candidate queue, oldest at index 0, values
    // strictly decreasing toward the back.
    // ------------------------------------------------------------------------
    logic signed [31:0] cand_val [WINDOW_DEPTH];
    int                 cand_age [WINDOW_DEPTH];
    int                 cand_cnt   = 0;
    int                 seen_cnt   = 0;
    logic [6:0]         win_reg    = 7'd1;

    // Window maxima still owed by the DUT, ring with free-running counters
    logic signed [31:0] pending_max [PEND_DEPTH];
    int                 pend_wr    = 0;
    int                 pend_rd    = 0;
    int                 err_count  = 0;
    int                 cycle_count = 0;

    // Idle control shared with the receiver process
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // Hand-typed expectation that travels with the item on the bus
    bit                 hint_typed = 1'b0;
    bit                 hint_has   = 1'b0;
    logic signed [31:0] hint_res   = '0;

    // Directed item table
    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
    typedef struct {
        row_kind_t          kind;
        logic [31:0]        data;      // sample, or register value
        logic               restart;
        bit                 typed;     // expectation typed in below
        bit                 has_res;
        logic signed [31:0] res;
    } stim_row_t;
    stim_row_t stim_rows [ROW_SLOTS];
    int        row_cnt = 0;

    // Zero acts as one, anything above the store depth acts as the depth
    function automatic int eff_window();
        if (win_reg == 7'd0)
            return 1;
        if (int'(win_reg) > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return int'(win_reg);
    endfunction

    // One step of the streaming maximum: age, expire the front, drop smaller
    // or equal tail entries, append, then report the front once the window
    // has filled since the last restart.
    function automatic void predict_window_max(input logic signed [31:0] smp,
                                               input logic rst,
                                               output bit produces,
                                               output logic signed [31:0] result);
        int w;
        int drop;
        int i;
        w = eff_window();
        if (rst) begin
            cand_cnt = 0;
            seen_cnt = 0;
        end
        for (i = 0; i < cand_cnt; i++)
            cand_age[i]++;
        drop = 0;
        while (drop < cand_cnt && cand_age[drop] >= w)
            drop++;
        if (drop > 0) begin
            for (i = 0; i + drop < cand_cnt; i++) begin
                cand_val[i] = cand_val[i + drop];
                cand_age[i] = cand_age[i + drop];
            end
            cand_cnt -= drop;
        end
        // equal older entries go too
        while (cand_cnt > 0 && cand_val[cand_cnt - 1] <= smp)
            cand_cnt--;
        if (cand_cnt < WINDOW_DEPTH) begin
            cand_val[cand_cnt] = smp;
            cand_age[cand_cnt] = 0;
            cand_cnt++;
        end
        // a shrunk window caps the count
        if (seen_cnt < w)
            seen_cnt++;
        if (seen_cnt > w)
            seen_cnt = w;
        produces = (seen_cnt >= w);
        result   = cand_val[0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [31:0] data,
                           input logic restart, input bit typed, input bit has_res,
                           input logic [31:0] res);
        stim_row_t r;
        r.kind    = kind;
        r.data    = data;
        r.restart = restart;
        r.typed   = typed;
        r.has_res = has_res;
        r.res     = res;
        stim_rows[row_cnt] = r;
        row_cnt++;
    endtask

    // Present one item and hold it until the handshake completes
    task automatic send_item(input logic [31:0] smp, input logic rst, input bit typed,
                             input bit has_res, input logic [31:0] res);
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_sample   <= smp;
        s_restart  <= rst;
        hint_typed <= typed;
        hint_has   <= has_res;
        hint_res   <= res;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Drop valid, wait out every owed result plus the pipe latency; items that
    // give no result may still be in flight when the queue runs empty.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write of window_size followed by a read-back
    task automatic write_window(input logic [31:0] value);
        wait_drained();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIN_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);            // written at the edge just passed
        psel    <= 1'b0;
        penable <= 1'b0;
        win_reg = value[6:0];
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {25'b0, value[6:0]})
            report_mismatch($sformatf("window_size read 0x%08h, wrote 0x%02h",
                                      prdata, value[6:0]));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls at the phase rate, plus a long hold-off on
    // request so the pipe holds and s_ready drops.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then predict for the item taken at this
    // edge. An item can never produce its result at the edge that takes it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor_blk
        bit                 has_res;
        logic signed [31:0] res;
        logic signed [31:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pend_wr == pend_rd) begin
                    report_mismatch($sformatf("unexpected result %0d", m_window_max));
                end else begin
                    want = pending_max[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    if (m_window_max !== want)
                        report_mismatch($sformatf("window_max %0d, expected %0d",
                                                  m_window_max, want));
                end
            end
            if (s_valid && s_ready) begin
                predict_window_max(s_sample, s_restart, has_res, res);
                if (hint_typed) begin
                    has_res = hint_has;
                    res     = hint_res;
                end
                if (has_res) begin
                    pending_max[pend_wr % PEND_DEPTH] = res;
                    pend_wr++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sliding_window_maximum regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus_blk
        int                 phase;
        int                 n;
        int                 w;
        int                 seq_left;
        int                 style;
        logic signed [31:0] ramp;
        logic signed [31:0] step;
        logic signed [31:0] v;
        logic               rs;
        logic [31:0]        cfg;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Window 1 after reset: every item echoes itself
        add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1, 1, 32'h8000_0000);
        add_row(ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 1, 1, 32'h7fff_ffff);
        add_row(ROW_SAMPLE, 32'h0000_0000, 1'b1, 1, 1, 32'h0000_0000);
        add_row(ROW_SAMPLE, 32'hffff_ffff, 1'b0, 1, 1, 32'hffff_ffff);
        add_row(ROW_SAMPLE, 32'h0000_0001, 1'b0, 1, 1, 32'h0000_0001);
        // Window size zero behaves as one
        add_row(ROW_WINDOW, 32'h0000_0000, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'h1234_5678, 1'b0, 1, 1, 32'h1234_5678);
        add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1, 1, 32'h8000_0000);
        // Window 3: fill phase gives nothing, then equal samples and expiry
        add_row(ROW_WINDOW, 32'h0000_0003, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'd5, 1'b1, 1, 0, '0);
        add_row(ROW_SAMPLE, 32'd9, 1'b0, 1, 0, '0);
        add_row(ROW_SAMPLE, 32'd9, 1'b0, 1, 1, 32'd9);
        add_row(ROW_SAMPLE, 32'd7, 1'b0, 1, 1, 32'd9);
        add_row(ROW_SAMPLE, 32'd3, 1'b0, 1, 1, 32'd9);
        add_row(ROW_SAMPLE, 32'd2, 1'b0, 1, 1, 32'd7);
        // Shrink to 2 mid-sequence: older candidates drop out
        add_row(ROW_WINDOW, 32'h0000_0002, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'd1, 1'b0, 1, 1, 32'd2);
        add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1, 1, 32'd1);
        // Grow to 5 mid-sequence: must refill before any result
        add_row(ROW_WINDOW, 32'h0000_0005, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'd4, 1'b0, 1, 0, '0);
        add_row(ROW_SAMPLE, 32'd4, 1'b0, 1, 0, '0);
        add_row(ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'hffff_ffff, 1'b0, 0, 0, '0);
        // Register value above the depth acts as the full depth
        add_row(ROW_WINDOW, 32'hffff_ff7f, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'h8000_0000, 1'b1, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 0, 0, '0);
        add_row(ROW_SAMPLE, 32'h0000_0000, 1'b0, 0, 0, '0);

        for (int r = 0; r < row_cnt; r++) begin
            if (stim_rows[r].kind == ROW_WINDOW)
                write_window(stim_rows[r].data);
            else
                send_item(stim_rows[r].data, stim_rows[r].restart, stim_rows[r].typed,
                          stim_rows[r].has_res, stim_rows[r].res);
        end

        // Random phases: each picks a window size and an idle pattern
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            cfg = $urandom();
            case (phase)
                0: cfg[6:0] = 7'd64;
                1: cfg[6:0] = 7'd1;
                2: cfg[6:0] = 7'($urandom_range(3, 12));
                3: cfg[6:0] = 7'd127;
                4: cfg[6:0] = 7'd0;
                5: cfg[6:0] = 7'd2;
                6: cfg[6:0] = 7'($urandom_range(13, 63));
                default: cfg[6:0] = 7'($urandom_range(65, 126));
            endcase
            write_window(cfg);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 69;
                end
                default: begin
                    send_idle_pct = 35;
                    recv_stall_pct = 35;
                end
            endcase
            w = eff_window();
            // half the time carry the old sequence across the size change
            seq_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2 * w);
            style = 0;
            ramp  = $urandom();
            step  = 1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                rs = 1'b0;
                if (seq_left == 0) begin
                    rs = 1'b1;
                    // mostly sequences long enough to fill the window; some stubs
                    seq_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                           : $urandom_range(w, 3 * w + 8);
                    style = $urandom_range(0, 4);
                    ramp  = $urandom();
                    step  = $urandom_range(0, 5);
                end
                seq_left--;
                if ($urandom_range(0, 49) == 0)
                    rs = 1'b1;          // stray restart
                case (style)
                    0: v = $urandom();
                    1: v = $urandom_range(0, 7) - 4;        // narrow range, many ties
                    2: begin                                // falling ramp fills the store
                        v = ramp;
                        ramp = ramp - step;
                    end
                    3: begin
                        v = ramp;
                        ramp = ramp + step;
                    end
                    default: begin
                        case ($urandom_range(0, 4))
                            0: v = 32'sh8000_0000;
                            1: v = 32'sh7fff_ffff;
                            2: v = 32'sh0;
                            3: v = -32'sd1;
                            default: v = $urandom();
                        endcase
                    end
                endcase
                if (phase == 0 && n == 150)
                    hold_requests++;    // long receiver hold-off, sender keeps presenting items
                while ($urandom_range(0, 99) < send_idle_pct) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
                send_item(v, rs, 0, 0, '0);
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("sliding_window_maximum regression: pass");
        else
            $display("sliding_window_maximum regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_node.sv
hw/rtl/sliding_window_maximum.sv
sim/testbench.sv
